[design/gbn_pkg.sv]
// Shared types and codes for the go-back-N send window unit.
package gbn_pkg;

  typedef enum logic [1:0] {
    REQ_CHUNK = 2'd0,
    REQ_ACK   = 2'd1,
    REQ_TIMER = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_SEND     = 3'd0,
    KIND_REFUSED  = 3'd1,
    KIND_APPLIED  = 3'd2,
    KIND_IGNORED  = 3'd3,
    KIND_COMPLETE = 3'd4,
    KIND_GAVE_UP  = 3'd5,
    KIND_NOTHING  = 3'd6,
    KIND_CLOSED   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    CL_OPEN    = 2'd0,
    CL_DONE    = 2'd1,
    CL_GAVE_UP = 2'd2
  } closed_t;

  // What a captured event turns into
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_RESEND = 2'd2
  } ev_class_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EVAL   = 2'd1,
    ST_RESEND = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic start_resend;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    ev_class_t ev;
    logic      out_free;
    logic      resend_last;
  } dp_status_t;

  localparam int CFG_WINDOW_USED   = 0;
  localparam int CFG_GIVE_UP_AFTER = 1;

  localparam logic [3:0] WINDOW_USED_RST   = 4'd8;
  localparam logic [2:0] GIVE_UP_AFTER_RST = 3'd5;
  localparam logic [2:0] TIMEOUT_MAX       = 3'd7;

endpackage

[design/gbn_ctrl.sv]
// Controller state machine: sequences capture, evaluation and resend bursts.
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        case (status.ev)
          EV_NONE:   state_next = ST_IDLE;
          EV_SINGLE: if (status.out_free) state_next = ST_IDLE;
          EV_RESEND: state_next = ST_RESEND;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_RESEND: begin
        if (status.out_free && status.resend_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    cmd              = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.apply        = (status.ev == EV_SINGLE) && status.out_free;
        cmd.start_resend = (status.ev == EV_RESEND);
      end
      ST_RESEND: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[design/gbn_dp.sv]
// Datapath: window state, event decode and the result register.
module gbn_dp
  import gbn_pkg::*;
#(
  parameter int WINDOW      = 8,
  parameter int CHUNK_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  req_type,
  input  logic [9:0]  chunk_len,
  input  logic [7:0]  ack_seq,
  input  logic [3:0]  window_used,
  input  logic [2:0]  give_up_after,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  kind,
  output logic [7:0]  seq,
  output logic [9:0]  length,
  output logic [3:0]  pending,
  output logic        last_of_run
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int EW = (CW > 4) ? CW : 4;
  localparam logic [9:0]  LEN_FULL = 10'(CHUNK_BYTES);
  localparam logic [12:0] CB13     = 13'(CHUNK_BYTES);

  // Held slots carry consecutive sequence numbers from base; only the final
  // chunk can be short, so one length register covers the whole window.
  logic [7:0]    base;
  logic [CW-1:0] cnt;
  logic [7:0]    next_seq;
  logic [7:0]    final_seq;
  logic [9:0]    final_len;
  logic          all_read;
  logic [2:0]    timeout_count;
  closed_t       closed_state;

  // Captured event
  req_t          req;
  logic [9:0]    clen;
  logic [7:0]    aseq;

  logic [CW-1:0] idx;

  // Decode
  logic          full;
  logic [EW-1:0] cnt_e;
  logic [EW-1:0] wu_e;
  logic [9:0]    sat_len;
  logic          is_final;
  logic [7:0]    diff;
  logic          hit;
  logic [CW-1:0] cnt_after_ack;
  logic          ack_done;
  logic [2:0]    tc_inc;
  logic          give;
  logic          out_free;

  kind_t         r_kind;
  logic [7:0]    r_seq;
  logic [9:0]    r_len;
  logic [CW-1:0] r_pend;

  logic [7:0]    rs_seq;
  logic [9:0]    rs_len;
  logic          rs_last;

  assign cnt_e = EW'(cnt);
  assign wu_e  = EW'((window_used == 4'd0) ? 4'd1 : window_used);
  assign full  = (cnt_e >= wu_e) || (cnt == CW'(WINDOW));

  assign sat_len  = ({3'b0, clen} > CB13) ? LEN_FULL : clen;
  assign is_final = {3'b0, sat_len} < CB13;

  assign diff          = aseq - base;
  assign hit           = diff < 8'(cnt);
  assign cnt_after_ack = cnt - diff[CW-1:0] - CW'(1);
  assign ack_done      = all_read && (aseq == final_seq);

  assign tc_inc = (timeout_count == TIMEOUT_MAX) ? TIMEOUT_MAX : timeout_count + 3'd1;
  assign give   = tc_inc >= give_up_after;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    status.out_free    = out_free;
    status.resend_last = rs_last;
    if (req == REQ_NONE) begin
      status.ev = EV_NONE;
    end else if (closed_state == CL_OPEN && req == REQ_TIMER && cnt != '0 && !give) begin
      status.ev = EV_RESEND;
    end else begin
      status.ev = EV_SINGLE;
    end
  end

  // Result of a one-result event
  always_comb begin
    r_kind = KIND_CLOSED;
    r_seq  = 8'd0;
    r_len  = 10'd0;
    r_pend = cnt;
    if (closed_state != CL_OPEN) begin
      r_kind = KIND_CLOSED;
    end else begin
      case (req)
        REQ_CHUNK: begin
          if (all_read || full) begin
            r_kind = KIND_REFUSED;
          end else begin
            r_kind = KIND_SEND;
            r_seq  = next_seq;
            r_len  = sat_len;
            r_pend = cnt + CW'(1);
          end
        end
        REQ_ACK: begin
          if (!hit) begin
            r_kind = KIND_IGNORED;
            r_seq  = aseq;
          end else begin
            r_kind = ack_done ? KIND_COMPLETE : KIND_APPLIED;
            r_seq  = aseq;
            r_pend = cnt_after_ack;
          end
        end
        REQ_TIMER: begin
          r_kind = (cnt == '0) ? KIND_NOTHING : KIND_GAVE_UP;
        end
        default: r_kind = KIND_CLOSED;
      endcase
    end
  end

  // Resend of the slot at idx
  assign rs_seq  = base + 8'(idx);
  assign rs_len  = (all_read && rs_seq == final_seq) ? final_len : LEN_FULL;
  assign rs_last = (idx == cnt - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      base          <= 8'd0;
      cnt           <= '0;
      next_seq      <= 8'd0;
      final_seq     <= 8'd0;
      all_read      <= 1'b0;
      timeout_count <= 3'd0;
      closed_state  <= CL_OPEN;
      req           <= REQ_NONE;
      idx           <= '0;
    end else begin
      if (cmd.capture) begin
        req <= req_t'(req_type);
      end
      if (cmd.start_resend) begin
        timeout_count <= tc_inc;
        idx           <= '0;
      end
      if (cmd.emit) begin
        idx <= idx + CW'(1);
      end
      if (cmd.apply && closed_state == CL_OPEN) begin
        case (req)
          REQ_CHUNK: begin
            if (!(all_read || full)) begin
              cnt <= cnt + CW'(1);
              if (cnt == '0) base <= next_seq;
              if (is_final) begin
                all_read  <= 1'b1;
                final_seq <= next_seq;
              end else begin
                next_seq <= next_seq + 8'd1;
              end
            end
          end
          REQ_ACK: begin
            if (hit) begin
              base          <= aseq + 8'd1;
              cnt           <= cnt_after_ack;
              timeout_count <= 3'd0;
              if (ack_done) closed_state <= CL_DONE;
            end
          end
          REQ_TIMER: begin
            if (cnt != '0) begin
              timeout_count <= tc_inc;
              closed_state  <= CL_GAVE_UP;
            end
          end
          default: begin
            req <= REQ_NONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      clen <= chunk_len;
      aseq <= ack_seq;
    end
    if (cmd.apply && closed_state == CL_OPEN && req == REQ_CHUNK && !(all_read || full)
        && is_final) begin
      final_len <= sat_len;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      kind        <= r_kind;
      seq         <= r_seq;
      length      <= r_len;
      pending     <= 4'(r_pend);
      last_of_run <= 1'b1;
    end else if (cmd.emit) begin
      kind        <= KIND_SEND;
      seq         <= rs_seq;
      length      <= rs_len;
      pending     <= 4'(cnt);
      last_of_run <= rs_last;
    end
  end

endmodule

[design/go_back_n_send_window_unit.sv]
// Top level of the go-back-N send window unit: config registers and wiring.
//
//   channel | signals                                     | beat when
//   --------+---------------------------------------------+--------------------------
//   in      | in_valid/in_ready, req_type chunk_len ack_seq | in_valid & in_ready
//   out     | out_valid/out_ready, kind seq length pending  | out_valid & out_ready
//           |   last_of_run                               |
//   cfg     | psel penable pwrite paddr pwdata prdata     | psel & penable & pwrite
//
// One event at a time: it is captured in the idle state, then evaluated, and a resend
// then sends every held slot in a burst, one result per cycle out of the single
// result register while that register is free.
// A full result register (out_ready low) stalls one-result evaluation and resends.
// Reset empties the window and opens the transfer; config returns to 8 and 5.
module go_back_n_send_window_unit
  import gbn_pkg::*;
#(
  parameter int WINDOW      = 8,
  parameter int CHUNK_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [9:0]  chunk_len,
  input  logic [7:0]  ack_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  seq,
  output logic [9:0]  length,
  output logic [3:0]  pending,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] window_used;
  logic [2:0] give_up_after;
  logic       cfg_wr;
  logic       cfg_sel;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_used   <= WINDOW_USED_RST;
      give_up_after <= GIVE_UP_AFTER_RST;
    end else if (cfg_wr) begin
      if (cfg_sel == 1'(CFG_WINDOW_USED)) begin
        window_used <= pwdata[3:0];
      end else begin
        give_up_after <= pwdata[2:0];
      end
    end
  end

  assign prdata = (cfg_sel == 1'(CFG_GIVE_UP_AFTER)) ? {29'd0, give_up_after}
                                                     : {28'd0, window_used};

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_dp #(
    .WINDOW      (WINDOW),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .chunk_len     (chunk_len),
    .ack_seq       (ack_seq),
    .window_used   (window_used),
    .give_up_after (give_up_after),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .kind          (kind),
    .seq           (seq),
    .length        (length),
    .pending       (pending),
    .last_of_run   (last_of_run)
  );

  // One event in flight: no second beat right after an accepted one
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an event is in flight");

  // Only a resend burst produces more than one result per event
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> (kind == KIND_SEND))
    else $error("non-final result that is not a resend");

  // Held count never exceeds the window
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(pending) <= 32'(WINDOW)))
    else $error("pending count above window size");

  // A result and a new event are never loaded in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && (cmd.apply || cmd.emit)))
    else $error("capture overlaps result load");

endmodule

[bench/go_back_n_send_window_unit_test.sv]
// Self-checking testbench for the go-back-N send window unit.
module go_back_n_send_window_unit_test;
  import gbn_pkg::*;

  localparam int WIN_SLOTS   = 8;
  localparam int CHUNK       = 512;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 12;
  localparam int RAND_EVENTS = 150;
  localparam logic [2:0] WIN_ADDR  = 3'(4 * CFG_WINDOW_USED);
  localparam logic [2:0] GIVE_ADDR = 3'(4 * CFG_GIVE_UP_AFTER);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] seq;
    logic [9:0] len;
    logic [3:0] pend;
    logic       last_run;
  } outcome_t;

  typedef enum {BY_MODEL, TYPED_ONE, TYPED_NONE} check_mode_t;

  typedef struct {
    req_t        rq;
    logic [9:0]  cl;
    logic [7:0]  ak;
    check_mode_t mode;
    outcome_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [9:0]  chunk_len;
  logic [7:0]  ack_seq;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [7:0]  seq;
  logic [9:0]  length;
  logic [3:0]  pending;
  logic        last_of_run;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  go_back_n_send_window_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .chunk_len(chunk_len), .ack_seq(ack_seq),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .seq(seq), .length(length), .pending(pending),
    .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // window model
  logic [3:0] win_reg;
  logic [2:0] give_reg;
  logic [7:0] held_seq [WIN_SLOTS];
  logic [9:0] held_len [WIN_SLOTS];
  int         held_n;
  logic [7:0] next_sq;
  logic [7:0] final_sq;
  bit         sent_final;
  bit         wrapped;
  logic [2:0] tmo_count;
  closed_t    close_st;

  outcome_t new_results [$];
  outcome_t due_results [$];
  dir_row_t dir_rows [$];

  bit calm;
  int mismatches;
  int beats_checked;
  int events_done;
  int chunks_taken;
  int acks_taken;
  int timer_events;
  int quiet_cycles;

  task automatic report_bad(string what, int got, int want);
    mismatches++;
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  function automatic int eff_window();
    if (win_reg == 0) return 1;
    if (win_reg > WIN_SLOTS) return WIN_SLOTS;
    return win_reg;
  endfunction

  function automatic void add_result(kind_t k, logic [7:0] s, logic [9:0] l, int p);
    outcome_t r;
    r.kind = k;
    r.seq = s;
    r.len = l;
    r.pend = 4'(p);
    r.last_run = 1'b0;
    new_results.push_back(r);
  endfunction

  task automatic predict_window_event(req_t rq, logic [9:0] cl, logic [7:0] ak);
    int p;
    int hit;
    logic [9:0] ln;
    new_results.delete();
    p = held_n;
    if (rq == REQ_NONE) return;
    if (close_st != CL_OPEN) begin
      add_result(KIND_CLOSED, 0, 0, p);
    end else if (rq == REQ_CHUNK) begin
      if (sent_final || p >= eff_window()) begin
        add_result(KIND_REFUSED, 0, 0, p);
      end else begin
        ln = (cl > CHUNK) ? 10'(CHUNK) : cl;
        held_seq[p] = next_sq;
        held_len[p] = ln;
        held_n = p + 1;
        chunks_taken++;
        add_result(KIND_SEND, next_sq, ln, p + 1);
        if (ln < CHUNK) begin
          sent_final = 1'b1;
          final_sq = next_sq;
        end else begin
          next_sq++;
          if (next_sq == 0) wrapped = 1'b1;
        end
      end
    end else if (rq == REQ_ACK) begin
      hit = -1;
      for (int i = 0; i < p; i++)
        if (hit < 0 && held_seq[i] == ak) hit = i;
      if (hit < 0) begin
        add_result(KIND_IGNORED, ak, 0, p);
      end else begin
        // cumulative ack: drop the matched slot and everything older
        for (int i = 0; i + hit + 1 < p; i++) begin
          held_seq[i] = held_seq[i + hit + 1];
          held_len[i] = held_len[i + hit + 1];
        end
        held_n = p - hit - 1;
        tmo_count = 0;
        acks_taken++;
        if (sent_final && ak == final_sq) begin
          close_st = CL_DONE;
          add_result(KIND_COMPLETE, final_sq, 0, held_n);
        end else begin
          add_result(KIND_APPLIED, ak, 0, held_n);
        end
      end
    end else begin
      timer_events++;
      if (p == 0) begin
        add_result(KIND_NOTHING, 0, 0, 0);
      end else begin
        if (tmo_count < TIMEOUT_MAX) tmo_count++;
        if (tmo_count >= give_reg) begin
          close_st = CL_GAVE_UP;
          add_result(KIND_GAVE_UP, 0, 0, p);
        end else begin
          for (int i = 0; i < p; i++)
            add_result(KIND_SEND, held_seq[i], held_len[i], p);
        end
      end
    end
    new_results[new_results.size() - 1].last_run = 1'b1;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic offer_event(req_t rq, logic [9:0] cl, logic [7:0] ak,
                             check_mode_t mode, outcome_t typed);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    chunk_len <= cl;
    ack_seq <= ak;
    do @(posedge clk); while (!in_ready);
    predict_window_event(rq, cl, ak);
    if (rq != REQ_NONE) events_done++;
    case (mode)
      BY_MODEL: foreach (new_results[i]) due_results.push_back(new_results[i]);
      TYPED_ONE: begin
        typed.last_run = 1'b1;
        due_results.push_back(typed);
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drop valid, wait for every due result, then give the unit time to go idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val, logic [31:0] mask);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == WIN_ADDR) win_reg = val[3:0];
    else give_reg = val[2:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== (val & mask)) report_bad("register readback", prdata, val & mask);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(req_t rq, int cl, int ak, check_mode_t m,
                                      kind_t k, int s, int l, int p);
    dir_row_t r;
    r.rq = rq;
    r.cl = 10'(cl);
    r.ak = 8'(ak);
    r.mode = m;
    r.want.kind = k;
    r.want.seq = 8'(s);
    r.want.len = 10'(l);
    r.want.pend = 4'(p);
    r.want.last_run = 1'b1;
    return r;
  endfunction

  // result side: random stall per beat, checks every beat against the oldest due result
  initial begin
    int stall;
    outcome_t want;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      beats_checked++;
      if (due_results.size() == 0) begin
        report_bad("beat with nothing due, kind", kind, -1);
      end else begin
        want = due_results.pop_front();
        if (kind !== want.kind) report_bad("kind", kind, want.kind);
        if (seq !== want.seq) report_bad("seq", seq, want.seq);
        if (length !== want.len) report_bad("length", length, want.len);
        if (pending !== want.pend) report_bad("pending", pending, want.pend);
        if (last_of_run !== want.last_run) report_bad("last_of_run", last_of_run, want.last_run);
      end
      @(negedge clk);
    end
  end

  // watchdog: too long without any beat or register access
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int roll;
    int seg;
    int rand_count;
    int path;
    req_t rq;
    logic [9:0] cl;
    logic [7:0] ak;
    logic [31:0] wv;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_NONE;
    chunk_len = '0;
    ack_seq = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    win_reg = WINDOW_USED_RST;
    give_reg = GIVE_UP_AFTER_RST;
    held_n = 0;
    next_sq = '0;
    final_sq = '0;
    sent_final = 1'b0;
    wrapped = 1'b0;
    tmo_count = '0;
    close_st = CL_OPEN;
    mismatches = 0;
    beats_checked = 0;
    events_done = 0;
    chunks_taken = 0;
    acks_taken = 0;
    timer_events = 0;
    quiet_cycles = 0;

    // directed: empty-window cases, saturation, resends, full window, cumulative ack
    dir_rows.push_back(mk_row(REQ_TIMER, 0, 0, TYPED_ONE, KIND_NOTHING, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_ACK, 0, 0, TYPED_ONE, KIND_IGNORED, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_NONE, 1023, 255, TYPED_NONE, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_CHUNK, 512, 0, TYPED_ONE, KIND_SEND, 0, 512, 1));
    dir_rows.push_back(mk_row(REQ_CHUNK, 1023, 0, TYPED_ONE, KIND_SEND, 1, 512, 2));
    dir_rows.push_back(mk_row(REQ_CHUNK, 513, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_TIMER, 0, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_ACK, 0, 255, TYPED_ONE, KIND_IGNORED, 255, 0, 3));
    dir_rows.push_back(mk_row(REQ_ACK, 0, 1, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_CHUNK, 600, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_CHUNK, 777, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_CHUNK, 1000, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_CHUNK, 512, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_CHUNK, 700, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_CHUNK, 1023, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_CHUNK, 900, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    // full window refuses, and a short chunk refused there is not the final one
    dir_rows.push_back(mk_row(REQ_CHUNK, 0, 0, TYPED_ONE, KIND_REFUSED, 0, 0, 8));
    dir_rows.push_back(mk_row(REQ_TIMER, 0, 0, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_ACK, 0, 9, BY_MODEL, KIND_SEND, 0, 0, 0));
    dir_rows.push_back(mk_row(REQ_TIMER, 0, 0, TYPED_ONE, KIND_NOTHING, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      offer_event(dir_rows[i].rq, dir_rows[i].cl, dir_rows[i].ak,
                  dir_rows[i].mode, dir_rows[i].want);

    // random segments, new settings between them
    seg = 0;
    rand_count = 0;
    while (rand_count < RAND_EVENTS) begin
      settle();
      case (seg)
        0: begin
          wv = ($urandom() & 32'hFFFF_FFF0) | 32'd0;
          write_reg(WIN_ADDR, wv, 32'hF);
          write_reg(GIVE_ADDR, ($urandom() & 32'hFFFF_FFF8) | 32'd7, 32'h7);
        end
        1: begin
          write_reg(WIN_ADDR, ($urandom() & 32'hFFFF_FFF0) | 32'd15, 32'hF);
          write_reg(GIVE_ADDR, ($urandom() & 32'hFFFF_FFF8) | 32'd1, 32'h7);
        end
        2: begin
          // window shrinks under held slots
          write_reg(WIN_ADDR, 32'd2, 32'hF);
          write_reg(GIVE_ADDR, 32'd3, 32'h7);
        end
        default: begin
          write_reg(WIN_ADDR, ($urandom() & 32'hFFFF_FFF0) | $urandom_range(0, 15), 32'hF);
          write_reg(GIVE_ADDR, ($urandom() & 32'hFFFF_FFF8) | $urandom_range(1, 7), 32'h7);
        end
      endcase
      calm = (seg == 1) || ($urandom_range(0, 4) == 0);
      repeat (30) begin
        roll = $urandom_range(0, 99);
        cl = 10'($urandom_range(0, 1023));
        ak = 8'($urandom_range(0, 255));
        if (roll < 55) begin
          rq = REQ_CHUNK;
          // keep accepted chunks full-sized so the transfer stays open
          if (held_n < eff_window())
            cl = ($urandom_range(0, 1) == 0) ? 10'(CHUNK) : 10'($urandom_range(513, 1023));
        end else if (roll < 88) begin
          rq = REQ_ACK;
          if (held_n > 0) ak = held_seq[$urandom_range(0, held_n - 1)];
        end else if (roll < 92) begin
          rq = REQ_ACK;
        end else if (roll < 97) begin
          // a timeout that would end the transfer becomes an ack of a held slot
          if (held_n == 0 || int'(tmo_count) + 1 < int'(give_reg)) begin
            rq = REQ_TIMER;
          end else begin
            rq = REQ_ACK;
            ak = held_seq[$urandom_range(0, held_n - 1)];
          end
        end else begin
          rq = REQ_NONE;
        end
        offer_event(rq, cl, ak, BY_MODEL, '0);
        if (rq != REQ_NONE) rand_count++;
      end
      seg++;
    end
    calm = 1'b0;

    // closing: final chunk, then either completion or give-up, then closed events
    settle();
    path = $urandom_range(0, 1);
    if (path == 1) write_reg(GIVE_ADDR, 32'($urandom_range(0, 7)), 32'h7);
    if (held_n >= eff_window())
      offer_event(REQ_ACK, 10'($urandom_range(0, 1023)), held_seq[held_n - 1], BY_MODEL, '0);
    offer_event(REQ_CHUNK, 10'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                BY_MODEL, '0);
    offer_event(REQ_CHUNK, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                BY_MODEL, '0);
    if (path == 0) begin
      offer_event(REQ_ACK, 10'($urandom_range(0, 1023)), final_sq, BY_MODEL, '0);
    end else begin
      while (close_st == CL_OPEN)
        offer_event(REQ_TIMER, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                    BY_MODEL, '0);
    end
    offer_event(REQ_CHUNK, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                BY_MODEL, '0);
    offer_event(REQ_ACK, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                BY_MODEL, '0);
    offer_event(REQ_TIMER, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                BY_MODEL, '0);
    offer_event(REQ_NONE, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                BY_MODEL, '0);
    settle();

    $display("Covered %0d events: %0d chunks taken, %0d acks applied, %0d timer expiries.",
             events_done, chunks_taken, acks_taken, timer_events);
    $display("%0d result beats checked; sequence wrapped: %s; transfer ended %s.",
             beats_checked, wrapped ? "yes" : "no",
             (close_st == CL_DONE) ? "complete" : "by give-up");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
